>>> sv/gha_pkg.sv
// shared types and codes for the generational handle allocator
package gha_pkg;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_CHECK   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DEAD = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage

>>> sv/gha_ctrl.sv
// controller state machine: accepts a transaction, then commits it to the datapath
module gha_ctrl
    import gha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/gha_datapath.sv
// datapath: slot memory, free stack, counters and output register
module gha_datapath
    import gha_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    parameter int GEN_BITS  = 16,
    parameter int IDX_W     = $clog2(MAX_SLOTS),
    parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          stat,
    input  logic [1:0]          op,
    input  logic [IDX_W-1:0]    handle_index,
    input  logic [GEN_BITS-1:0] handle_generation,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    out_index,
    output logic [GEN_BITS-1:0] out_generation,
    output logic                success,
    output logic [1:0]          status,
    output logic [CNT_W-1:0]    live_total
);

    localparam int SLOT_W = GEN_BITS + 1;
    localparam int STK_W  = IDX_W + GEN_BITS;

    // slot word: live flag over generation; stack word: index over generation
    logic [SLOT_W-1:0] slot_mem [MAX_SLOTS];
    logic [STK_W-1:0]  stk_mem  [MAX_SLOTS];

    op_t               op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [GEN_BITS-1:0] gen_reg;
    logic [SLOT_W-1:0] slot_rd_reg;
    logic [STK_W-1:0]  stk_rd_reg;

    logic [CNT_W-1:0] free_depth_reg, free_depth_next;
    logic [CNT_W-1:0] high_water_reg, high_water_next;
    logic [CNT_W-1:0] live_cnt_reg, live_cnt_next;

    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_index_reg, out_index_next;
    logic [GEN_BITS-1:0] out_gen_reg, out_gen_next;
    logic                success_reg, success_next;
    status_t             status_reg, status_next;

    logic [CNT_W-1:0]    depth_dec;
    logic [IDX_W-1:0]    stk_top;
    logic                live_hit;
    logic [GEN_BITS-1:0] gen_inc;

    logic                slot_we;
    logic [IDX_W-1:0]    slot_waddr;
    logic [SLOT_W-1:0]   slot_wdata;
    logic                stk_we;
    logic [STK_W-1:0]    stk_wdata;

    assign depth_dec = free_depth_reg - CNT_W'(1);
    assign stk_top   = depth_dec[IDX_W-1:0];
    assign gen_inc   = gen_reg + GEN_BITS'(1);

    assign live_hit = (CNT_W'(idx_reg) < high_water_reg) && slot_rd_reg[SLOT_W-1]
                      && (slot_rd_reg[GEN_BITS-1:0] == gen_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op_t'(op);
            idx_reg     <= handle_index;
            gen_reg     <= handle_generation;
            slot_rd_reg <= slot_mem[handle_index];
            stk_rd_reg  <= stk_mem[stk_top];
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (stk_we)
        begin
            stk_mem[free_depth_reg[IDX_W-1:0]] <= stk_wdata;
        end
    end

    always_comb
    begin
        free_depth_next = free_depth_reg;
        high_water_next = high_water_reg;
        live_cnt_next   = live_cnt_reg;
        out_index_next  = idx_reg;
        out_gen_next    = gen_reg;
        success_next    = 1'b0;
        status_next     = STAT_OK;
        slot_we         = 1'b0;
        slot_waddr      = idx_reg;
        slot_wdata      = {1'b0, gen_inc};
        stk_we          = 1'b0;
        stk_wdata       = {idx_reg, gen_inc};
        case (op_reg)
            OP_CREATE:
            begin
                if (free_depth_reg != '0)
                begin
                    free_depth_next = depth_dec;
                    out_index_next  = stk_rd_reg[STK_W-1:GEN_BITS];
                    out_gen_next    = stk_rd_reg[GEN_BITS-1:0];
                    success_next    = 1'b1;
                end
                else if (high_water_reg < CNT_W'(MAX_SLOTS))
                begin
                    high_water_next = high_water_reg + CNT_W'(1);
                    out_index_next  = high_water_reg[IDX_W-1:0];
                    out_gen_next    = '0;
                    success_next    = 1'b1;
                end
                else
                begin
                    status_next = STAT_FULL;
                end
                if (success_next)
                begin
                    live_cnt_next = live_cnt_reg + CNT_W'(1);
                    slot_we       = 1'b1;
                    slot_waddr    = out_index_next;
                    slot_wdata    = {1'b1, out_gen_next};
                end
            end
            OP_DESTROY:
            begin
                if (live_hit)
                begin
                    success_next = 1'b1;
                    slot_we      = 1'b1;
                    if (free_depth_reg < CNT_W'(MAX_SLOTS))
                    begin
                        stk_we          = 1'b1;
                        free_depth_next = free_depth_reg + CNT_W'(1);
                    end
                    if (live_cnt_reg != '0)
                    begin
                        live_cnt_next = live_cnt_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    status_next = STAT_DEAD;
                end
            end
            OP_CHECK:
            begin
                if (live_hit)
                begin
                    success_next = 1'b1;
                end
                else
                begin
                    status_next = STAT_DEAD;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
        if (!cmd.commit)
        begin
            slot_we = 1'b0;
            stk_we  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_depth_reg <= '0;
            high_water_reg <= '0;
            live_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                free_depth_reg <= free_depth_next;
                high_water_reg <= high_water_next;
                live_cnt_reg   <= live_cnt_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_index_reg <= out_index_next;
            out_gen_reg   <= out_gen_next;
            success_reg   <= success_next;
            status_reg    <= status_next;
        end
    end

    assign stat.out_stall = out_valid_reg && !out_ready;

    assign out_valid      = out_valid_reg;
    assign out_index      = out_index_reg;
    assign out_generation = out_gen_reg;
    assign success        = success_reg;
    assign status         = status_reg;
    assign live_total     = live_cnt_reg;

endmodule

>>> sv/generational_handle_allocator_core.sv
// top level of the generational handle allocator
// For each transaction, at the accepting edge the slot memory (live flag and
// generation) and the top of the free stack are read, and in the execute state the
// handle is compared, both memories are written back and the result goes into the output
// register. A new transaction is taken the cycle after that write-back, even while the
// previous result still waits at the output; the execute state stalls only if that
// result has not left by then. One transaction is in flight at a time: the registered
// memory read precedes its write-back. Slots above the high-water mark are treated as
// fresh with generation zero, so the memories need no clearing pass after reset.
module generational_handle_allocator_core
    import gha_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    parameter int GEN_BITS  = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic [$clog2(MAX_SLOTS)-1:0]        handle_index,
    input  logic [GEN_BITS-1:0]                 handle_generation,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [$clog2(MAX_SLOTS)-1:0]        out_index,
    output logic [GEN_BITS-1:0]                 out_generation,
    output logic                                success,
    output logic [1:0]                          status,
    output logic [$clog2(MAX_SLOTS+1)-1:0]      live_total
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    gha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gha_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .GEN_BITS  (GEN_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .op                (op),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .success           (success),
        .status            (status),
        .live_total        (live_total)
    );

endmodule

>>> sv/gha_checker.sv
// port-level checks for the generational handle allocator, bound to the top level
module gha_checker
    import gha_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    parameter int GEN_BITS  = 16
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [$clog2(MAX_SLOTS)-1:0]   out_index,
    input logic [GEN_BITS-1:0]            out_generation,
    input logic                           success,
    input logic [1:0]                     status,
    input logic [$clog2(MAX_SLOTS+1)-1:0] live_total
);

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    // a result that waits keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index)
        && $stable(out_generation) && $stable(success) && $stable(status)
        && $stable(live_total))
    else $error("output transaction changed while stalled");

    // one transaction in flight: no back-to-back accepts
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

    a_success_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && success |-> status == STAT_OK)
    else $error("success with nonzero status");

    // full only when every slot is live
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> !success && live_total == CNT_W'(MAX_SLOTS))
    else $error("table full reported with free slots");

endmodule

bind generational_handle_allocator_core gha_checker #(
    .MAX_SLOTS (MAX_SLOTS),
    .GEN_BITS  (GEN_BITS)
) u_gha_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_index      (out_index),
    .out_generation (out_generation),
    .success        (success),
    .status         (status),
    .live_total     (live_total)
);
